// ===== rtl/dqir_pkg.sv =====
package dqir_pkg;

  localparam int unsigned MaxPendingDef = 16;

  localparam int unsigned IdW   = 16;
  localparam int unsigned IpW   = 32;
  localparam int unsigned PortW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned SeqW  = 8;
  localparam int unsigned CfgW  = 32;

  localparam logic [IpW-1:0]   UpstreamIpRst   = '0;
  localparam logic [PortW-1:0] UpstreamPortRst = 16'd53;
  localparam logic [IpW-1:0]   ListenIpRst     = '0;
  localparam logic [15:0]      TimeoutMsRst    = 16'd5000;

  typedef enum logic [1:0] {
    OP_QUERY    = 2'd0,
    OP_RESPONSE = 2'd1,
    OP_TICK     = 2'd2,
    OP_RSVD     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_DROP     = 2'd0,
    ACT_FORWARD  = 2'd1,
    ACT_SERVFAIL = 2'd2,
    ACT_RESPONSE = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    CFG_UPSTREAM_IP   = 2'd0,
    CFG_UPSTREAM_PORT = 2'd1,
    CFG_LISTEN_IP     = 2'd2,
    CFG_TIMEOUT_MS    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FINISH,
    ST_CHK,
    ST_EMIT
  } state_e;

  // one pending query as held in the slot memory
  typedef struct packed {
    logic [IdW-1:0]   client_id;
    logic [SeqW-1:0]  seq;
    logic [IpW-1:0]   client_ip;
    logic [PortW-1:0] client_port;
    logic [TimeW-1:0] deadline;
  } rec_t;

endpackage

// ===== rtl/dqir_ram.sv =====
module dqir_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/dns_query_id_remap_table.sv =====
// pending-query table of a dns forwarder
// input channel: in_valid_i / in_stall_o with opcode, time, id and peer fields;
// an item is taken when valid is high and stall is low. output channel:
// out_valid_o / out_stall_i with action, out_id, dest_ip, dest_port; every
// item gives exactly one result, a drop included
// one item is worked at a time. from acceptance to the result sitting in the
// output register, a query with a usable upstream and an expiry tick pass
// DECODE, SCAN and FINISH (the expiry and free-slot search reads the slot
// memory one entry per cycle through its single read port), a response to a
// pending slot passes DECODE and CHK and other items DECODE alone; each then
// waits in EMIT until the output register is free
// the next item is taken once the result has moved into the output register,
// so a waiting result does not block intake. when the receiver stalls, the
// result holds in the output register and the following result waits in its
// own register until the output frees up. reset (asynchronous, active low)
// empties the table via per-slot used flags, clears the sequence and loads the
// register defaults; the slot memory needs no clearing pass. the user makes
// config writes only while the block is idle, which the block does not enforce
module dns_query_id_remap_table
  import dqir_pkg::*;
#(
  parameter int unsigned MaxPending = MaxPendingDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // config write port
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  // input items
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       opcode_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic [IdW-1:0]   txn_id_i,
  input  logic             is_query_i,
  input  logic [IpW-1:0]   peer_ip_i,
  input  logic [PortW-1:0] peer_port_i,
  // result items
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       action_o,
  output logic [IdW-1:0]   out_id_o,
  output logic [IpW-1:0]   dest_ip_o,
  output logic [PortW-1:0] dest_port_o
);

  localparam int unsigned IdxW = (MaxPending > 1) ? $clog2(MaxPending) : 1;
  localparam int unsigned CntW = $clog2(MaxPending + 1);
  localparam int unsigned RecW = $bits(rec_t);

  // config registers
  logic [IpW-1:0]   upstream_ip_q;
  logic [PortW-1:0] upstream_port_q;
  logic [IpW-1:0]   listen_ip_q;
  logic [15:0]      timeout_ms_q;

  // control state
  state_e              state_q, state_d;
  logic [MaxPending-1:0] used_q;
  logic [SeqW-1:0]     seq_q;
  logic [CntW-1:0]     cnt_q;
  logic                chk_vld_q;
  logic                found_q;
  logic                out_valid_q;

  // latched item and scan payload
  op_e                 op_q;
  logic [TimeW-1:0]    now_q;
  logic [IdW-1:0]      txn_q;
  logic                is_query_q;
  logic [IpW-1:0]      pip_q;
  logic [PortW-1:0]    pport_q;
  logic [IdxW-1:0]     chk_idx_q;
  logic [IdxW-1:0]     free_idx_q;

  // pending result and output register
  act_e                res_act_q;
  logic [IdW-1:0]      res_id_q;
  logic [IpW-1:0]      res_ip_q;
  logic [PortW-1:0]    res_port_q;
  logic [1:0]          out_act_q;
  logic [IdW-1:0]      out_id_q;
  logic [IpW-1:0]      out_ip_q;
  logic [PortW-1:0]    out_port_q;

  // slot memory port
  logic                ram_we, ram_re;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;
  rec_t                ram_wdata, ram_rdata;
  logic [RecW-1:0]     ram_rdata_raw;

  // result load
  logic                res_we;
  act_e                res_act;
  logic [IdW-1:0]      res_id;
  logic [IpW-1:0]      res_ip;
  logic [PortW-1:0]    res_port;

  logic                up_ok;
  logic                out_free;
  logic                slot_ok;
  logic [IdxW-1:0]     slot_idx;
  logic                scan_issue;
  logic                scan_done;
  logic [TimeW-1:0]    age;
  logic                expired;
  logic                is_free;
  logic                resp_match;
  logic [IdW-1:0]      new_oid;

  assign up_ok    = (upstream_ip_q != '0) && (upstream_ip_q != listen_ip_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // slot number lives in the high byte of the id
  assign slot_ok  = {1'b0, txn_q[15:8]} < 9'(MaxPending);
  assign slot_idx = txn_q[8 +: IdxW];

  assign scan_issue = cnt_q < CntW'(MaxPending);
  assign scan_done  = (cnt_q == CntW'(MaxPending)) && !chk_vld_q;

  // wrapped difference, sign bit clear means the deadline has passed
  assign ram_rdata = rec_t'(ram_rdata_raw);
  assign age       = now_q - ram_rdata.deadline;
  assign expired   = used_q[chk_idx_q] && !age[TimeW-1];
  assign is_free   = !used_q[chk_idx_q] || expired;

  assign resp_match = (ram_rdata.seq == txn_q[7:0]) && up_ok &&
                      (pip_q == upstream_ip_q) && (pport_q == upstream_port_q);

  assign new_oid = {8'(free_idx_q), seq_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (op_q)
          OP_QUERY:    state_d = (is_query_q && up_ok) ? ST_SCAN : ST_EMIT;
          OP_RESPONSE: state_d = (slot_ok && used_q[slot_idx]) ? ST_CHK : ST_EMIT;
          OP_TICK:     state_d = ST_SCAN;
          default:     state_d = ST_EMIT;
        endcase
      end
      ST_SCAN: begin
        if (scan_done) state_d = ST_FINISH;
      end
      ST_FINISH: state_d = ST_EMIT;
      ST_CHK:    state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: memory port and result load
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = free_idx_q;
    ram_raddr = cnt_q[IdxW-1:0];
    ram_wdata = '{client_id:   txn_q,
                  seq:         seq_q,
                  client_ip:   pip_q,
                  client_port: pport_q,
                  deadline:    now_q + TimeW'(timeout_ms_q)};
    res_we    = 1'b0;
    res_act   = ACT_DROP;
    res_id    = '0;
    res_ip    = '0;
    res_port  = '0;
    unique case (state_q)
      ST_IDLE: ;
      ST_DECODE: begin
        unique case (op_q)
          OP_QUERY: begin
            if (!is_query_q) begin
              res_we = 1'b1;
            end else if (!up_ok) begin
              res_we   = 1'b1;
              res_act  = ACT_SERVFAIL;
              res_id   = txn_q;
              res_ip   = pip_q;
              res_port = pport_q;
            end
          end
          OP_RESPONSE: begin
            ram_re    = 1'b1;
            ram_raddr = slot_idx;
            if (!(slot_ok && used_q[slot_idx])) res_we = 1'b1;
          end
          OP_TICK: ;
          default: res_we = 1'b1;
        endcase
      end
      ST_SCAN: begin
        ram_re = scan_issue;
      end
      ST_FINISH: begin
        res_we = 1'b1;
        if (op_q == OP_QUERY) begin
          if (found_q) begin
            ram_we   = 1'b1;
            res_act  = ACT_FORWARD;
            res_id   = new_oid;
            res_ip   = upstream_ip_q;
            res_port = upstream_port_q;
          end else begin
            res_act  = ACT_SERVFAIL;
            res_id   = txn_q;
            res_ip   = pip_q;
            res_port = pport_q;
          end
        end
      end
      ST_CHK: begin
        res_we = 1'b1;
        if (resp_match) begin
          res_act  = ACT_RESPONSE;
          res_id   = ram_rdata.client_id;
          res_ip   = ram_rdata.client_ip;
          res_port = ram_rdata.client_port;
        end
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      used_q          <= '0;
      seq_q           <= '0;
      cnt_q           <= '0;
      chk_vld_q       <= 1'b0;
      found_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      upstream_ip_q   <= UpstreamIpRst;
      upstream_port_q <= UpstreamPortRst;
      listen_ip_q     <= ListenIpRst;
      timeout_ms_q    <= TimeoutMsRst;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_UPSTREAM_IP:   upstream_ip_q   <= cfg_wdata_i;
          CFG_UPSTREAM_PORT: upstream_port_q <= cfg_wdata_i[PortW-1:0];
          CFG_LISTEN_IP:     listen_ip_q     <= cfg_wdata_i;
          CFG_TIMEOUT_MS:    timeout_ms_q    <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      if (state_q == ST_DECODE) begin
        cnt_q     <= '0;
        chk_vld_q <= 1'b0;
        found_q   <= 1'b0;
      end

      if (state_q == ST_SCAN) begin
        if (scan_issue) cnt_q <= cnt_q + 1'b1;
        chk_vld_q <= scan_issue;
        if (chk_vld_q) begin
          if (expired) used_q[chk_idx_q] <= 1'b0;
          if (is_free) found_q <= 1'b1;
        end
      end

      if (state_q == ST_FINISH && op_q == OP_QUERY && found_q) begin
        used_q[free_idx_q] <= 1'b1;
        seq_q              <= seq_q + 1'b1;
      end

      if (state_q == ST_CHK && resp_match) begin
        used_q[slot_idx] <= 1'b0;
      end

      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      op_q       <= op_e'(opcode_i);
      now_q      <= now_ms_i;
      txn_q      <= txn_id_i;
      is_query_q <= is_query_i;
      pip_q      <= peer_ip_i;
      pport_q    <= peer_port_i;
    end
    if (state_q == ST_SCAN) begin
      chk_idx_q <= cnt_q[IdxW-1:0];
      // lowest free slot wins, scan runs upwards
      if (chk_vld_q && is_free && !found_q) free_idx_q <= chk_idx_q;
    end
    if (res_we) begin
      res_act_q  <= res_act;
      res_id_q   <= res_id;
      res_ip_q   <= res_ip;
      res_port_q <= res_port;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_act_q  <= res_act_q;
      out_id_q   <= res_id_q;
      out_ip_q   <= res_ip_q;
      out_port_q <= res_port_q;
    end
  end

  dqir_ram #(
    .Width (RecW),
    .Depth (MaxPending)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign action_o    = out_act_q;
  assign out_id_o    = out_id_q;
  assign dest_ip_o   = out_ip_q;
  assign dest_port_o = out_port_q;

endmodule
